@@ hw/rtl/sdr_pkg.sv @@
// Shared types, constants and helper functions of the spectrum dose-rate block.
package sdr_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TOTAL = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_BACK      = 3'd3;
    localparam logic [2:0] ST_NO_ADV    = 3'd4;
    localparam logic [2:0] ST_SMALL     = 3'd5;
    localparam logic [2:0] ST_BAD_INST  = 3'd6;
    localparam logic [2:0] ST_LEN       = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_DZ_SCALE  = 2'd0;
    localparam logic [1:0] CFG_MIN_DELTA = 2'd1;
    localparam logic [1:0] CFG_TIME_EPS  = 2'd2;
    localparam logic [1:0] CFG_CLOCK_HZ  = 2'd3;

    // Weight width covers (4095 - 10) * 96 with sign
    localparam int WGT_W   = 21;
    // Serial divider dividend: 96-bit product shifted left by 6
    localparam int DIV_N_W = 102;
    // Front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [31:0] dz_scale;
        logic [31:0] min_delta;
        logic [31:0] time_eps;
        logic [31:0] core_clock_hz;
    } cfg_t;

    typedef struct packed {
        logic [31:0]      x;
        logic [WGT_W-1:0] weight;
        logic             last;
        logic [2:0]       verdict;
        logic [31:0]      live;
        logic [63:0]      ticks;
        logic [15:0]      total;
    } item_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic first_pending;
    } back_ctl_t;

    // {valid, k}: total is 128 << k for k in 0..5
    function automatic logic [3:0] size_code(input logic [15:0] total);
        logic [3:0] r;
        r = 4'd0;
        for (int k = 0; k < 6; k++) begin
            if (total == (16'd128 << k)) begin
                r = {1'b1, 3'(k)};
            end
        end
        return r;
    endfunction

    // 96 >> k
    function automatic logic [6:0] weight_step(input logic [2:0] k);
        return 7'd96 >> k;
    endfunction

endpackage

@@ hw/rtl/sdr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sdr_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/sdr_fifo.sv @@
// Short request queue between the front and the back part.
module sdr_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sdr_pkg::item_t din,
    output logic          full,
    input  logic          pop,
    output sdr_pkg::item_t dout,
    output logic          empty
);
    import sdr_pkg::*;

    item_t         q_mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   fill_reg, fill_next;

    assign full  = (fill_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty = (fill_reg == '0);
    assign dout  = q_mem[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store a request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("request queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("request queue underflow");
`endif

endmodule

@@ hw/rtl/sdr_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, 32-bit quotient with an overflow flag.
module sdr_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sdr_pkg::DIV_N_W-1:0]  dividend,
    input  logic [31:0]                  divisor,
    output logic                         done,
    output logic [31:0]                  quot,
    output logic                         ovf
);
    import sdr_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_N_W-1:0] num_reg, num_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic [31:0]        q_reg, q_next;
    logic               ovf_reg, ovf_next;
    logic [32:0]        trial;
    logic               fits;

    // One compare-and-subtract step
    assign trial = {rem_reg, num_reg[DIV_N_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_N_W-2:0], 1'b0};
            rem_next = fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            q_next   = {q_reg[30:0], fits};
            ovf_next = ovf_reg | q_reg[31];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

@@ hw/rtl/sdr_front.sv @@
// Front part: accept channel requests, classify them, form the channel increase.
module sdr_front #(
    parameter int MAX_CHANNELS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [31:0]                       channel_count,
    input  logic [15:0]                       channel_total,
    input  logic [31:0]                       live_time,
    input  logic [63:0]                       record_ticks,
    input  logic                              last_channel,
    input  sdr_pkg::back_ctl_t                ctl,
    output logic                              prev_re,
    output logic [$clog2(MAX_CHANNELS)-1:0]   prev_raddr,
    input  logic [31:0]                       prev_rdata,
    output logic                              stg_we,
    output logic [$clog2(MAX_CHANNELS)-1:0]   stg_waddr,
    output logic [31:0]                       stg_wdata,
    output logic                              q_push,
    output sdr_pkg::item_t                    q_din,
    input  logic                              q_full
);
    import sdr_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHANNELS);
    localparam int CNT_W = IDX_W + 1;

    logic             accept;
    logic [CNT_W-1:0] idx_reg, idx_next, idx_inc;
    logic [2:0]       verdict_reg, verdict_next, verdict_upd;
    logic             hold_reg, hold_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_acc_reg;
    logic [31:0]      s1_count_reg;
    logic [WGT_W-1:0] s1_weight_reg;
    logic             s1_last_reg;
    logic [2:0]       s1_verdict_reg;
    logic [31:0]      s1_live_reg;
    logic [63:0]      s1_ticks_reg;
    logic [15:0]      s1_total_reg;

    logic [3:0]              sz;
    logic                    size_ok;
    logic                    in_range;
    logic signed [CNT_W:0]   ofs;
    logic signed [CNT_W+8:0] wfull;
    logic [31:0]             x;

    // Classify the request
    assign sz       = size_code(channel_total);
    assign size_ok  = sz[3] && (17'(channel_total) <= 17'(MAX_CHANNELS));
    assign in_range = size_ok && (17'(idx_reg) < 17'(channel_total));
    assign ofs      = $signed({1'b0, idx_reg}) - $signed((CNT_W+1)'(10));
    assign wfull    = ofs * $signed({1'b0, weight_step(sz[2:0])});
    assign idx_inc  = (idx_reg == CNT_W'(MAX_CHANNELS)) ? idx_reg : idx_reg + 1'b1;

    assign q_push   = s1_valid_reg && !q_full;
    assign in_stall = hold_reg || !ctl.ready || (s1_valid_reg && q_full);
    assign accept   = in_valid && !in_stall;

    // Read the previous count, stage the current one
    assign prev_re    = accept && in_range;
    assign prev_raddr = idx_reg[IDX_W-1:0];
    assign stg_we     = accept && in_range;
    assign stg_waddr  = idx_reg[IDX_W-1:0];
    assign stg_wdata  = channel_count;

    // Verdict and index update
    always_comb
    begin
        verdict_upd = verdict_reg;
        if (verdict_reg == ST_OK)
        begin
            if (!size_ok)
            begin
                verdict_upd = ST_BAD_TOTAL;
            end
            else if (!in_range)
            begin
                verdict_upd = ST_LEN;
            end
            else if (last_channel && (17'(idx_inc) != 17'(channel_total)))
            begin
                verdict_upd = ST_LEN;
            end
        end
        idx_next      = idx_reg;
        verdict_next  = verdict_reg;
        hold_next     = hold_reg;
        s1_valid_next = s1_valid_reg && !q_push;
        if (ctl.done)
        begin
            hold_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (last_channel)
            begin
                idx_next     = '0;
                verdict_next = ST_OK;
                hold_next    = 1'b1;
            end
            else
            begin
                idx_next     = idx_inc;
                verdict_next = verdict_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            verdict_reg  <= ST_OK;
            hold_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            verdict_reg  <= verdict_next;
            hold_reg     <= hold_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Hold the request in the staging register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_acc_reg     <= in_range;
            s1_count_reg   <= channel_count;
            s1_weight_reg  <= WGT_W'(wfull);
            s1_last_reg    <= last_channel;
            s1_verdict_reg <= verdict_upd;
            s1_live_reg    <= live_time;
            s1_ticks_reg   <= record_ticks;
            s1_total_reg   <= channel_total;
        end
    end

    // Increase over the previous spectrum, clipped at zero
    always_comb
    begin
        x = '0;
        if (s1_acc_reg)
        begin
            if (ctl.first_pending)
            begin
                x = s1_count_reg;
            end
            else if (s1_count_reg > prev_rdata)
            begin
                x = s1_count_reg - prev_rdata;
            end
        end
        q_din.x       = x;
        q_din.weight  = s1_weight_reg;
        q_din.last    = s1_last_reg;
        q_din.verdict = s1_verdict_reg;
        q_din.live    = s1_live_reg;
        q_din.ticks   = s1_ticks_reg;
        q_din.total   = s1_total_reg;
    end

`ifndef SYNTHESIS
    a_hold_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> in_stall)
        else $error("request taken while a spectrum is being finished");
`endif

endmodule

@@ hw/rtl/sdr_back.sv @@
// Back part: weighted accumulation, time checks, rate division and spectrum copy.
module sdr_back #(
    parameter int MAX_CHANNELS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdr_pkg::cfg_t                     cfg,
    input  sdr_pkg::item_t                    q_dout,
    input  logic                              q_empty,
    output logic                              q_pop,
    output sdr_pkg::back_ctl_t                ctl,
    output logic                              prev_we,
    output logic [$clog2(MAX_CHANNELS)-1:0]   prev_waddr,
    output logic [31:0]                       prev_wdata,
    output logic                              stg_re,
    output logic [$clog2(MAX_CHANNELS)-1:0]   stg_raddr,
    input  logic [31:0]                       stg_rdata,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                dose_rate,
    output logic [2:0]                        status
);
    import sdr_pkg::*;

    localparam int IDX_W  = $clog2(MAX_CHANNELS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int PROD_W = 33 + WGT_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_ACC  = 4'd1;
    localparam logic [3:0] S_FIN0 = 4'd2;
    localparam logic [3:0] S_FIN1 = 4'd3;
    localparam logic [3:0] S_TDIV = 4'd4;
    localparam logic [3:0] S_TCHK = 4'd5;
    localparam logic [3:0] S_MUL0 = 4'd6;
    localparam logic [3:0] S_MUL1 = 4'd7;
    localparam logic [3:0] S_MADD = 4'd8;
    localparam logic [3:0] S_RDIV = 4'd9;
    localparam logic [3:0] S_RES  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;
    localparam logic [3:0] S_COPY = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0]         state_reg, state_next;
    logic [63:0]        sum_reg, sum_next;
    logic               pa_valid_reg, pa_valid_next;
    logic [PROD_W-1:0]  pa_prod_reg;
    logic               fp_reg, fp_next;
    logic [31:0]        prev_live_reg, prev_live_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               cp_wv_reg, cp_wv_next;
    logic [IDX_W-1:0]   cp_wa_reg;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_rate_reg, out_rate_next;
    logic [2:0]         out_status_reg, out_status_next;

    logic [31:0]        fin_live_reg;
    logic [63:0]        fin_ticks_reg;
    logic [15:0]        fin_total_reg;
    logic [2:0]         fin_verdict_reg;
    logic [2:0]         stat_reg, stat_next;
    logic [31:0]        den_reg, den_next;
    logic [63:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [63:0]        pp_lo_reg, pp_hi_reg;
    logic [31:0]        rate_reg, rate_next;

    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [31:0]        div_quot;
    logic               div_ovf;

    logic signed [33:0] d_s, eps_s, min_s;
    logic [95:0]        n96;
    logic [32:0]        q33, qc;
    logic               cp_more;

    assign q_pop = (state_reg == S_ACC) && !q_empty;

    assign d_s   = $signed({2'b00, fin_live_reg}) - $signed({2'b00, prev_live_reg});
    assign eps_s = $signed({2'b00, cfg.time_eps});
    assign min_s = $signed({2'b00, cfg.min_delta});
    assign n96   = {pp_hi_reg, 32'd0} + {32'd0, pp_lo_reg};
    assign q33   = div_ovf ? 33'h1_0000_0000 : {1'b0, div_quot};
    assign cp_more = (17'(cnt_reg) < 17'(fin_total_reg));

    sdr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .ovf      (div_ovf)
    );

    // Clear and copy into the previous-spectrum memory
    assign stg_re     = (state_reg == S_COPY) && cp_more;
    assign stg_raddr  = cnt_reg[IDX_W-1:0];
    assign prev_we    = (state_reg == S_CLR) || cp_wv_reg;
    assign prev_waddr = (state_reg == S_CLR) ? cnt_reg[IDX_W-1:0] : cp_wa_reg;
    assign prev_wdata = (state_reg == S_CLR) ? 32'd0 : stg_rdata;

    assign ctl.ready         = (state_reg != S_CLR);
    assign ctl.done          = (state_reg == S_DONE);
    assign ctl.first_pending = fp_reg;

    // Sequence the spectrum end
    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        pa_valid_next   = q_pop;
        fp_next         = fp_reg;
        prev_live_next  = prev_live_reg;
        cnt_next        = cnt_reg;
        cp_wv_next      = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        out_rate_next   = out_rate_reg;
        out_status_next = out_status_reg;
        stat_next       = stat_reg;
        den_next        = den_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        rate_next       = rate_reg;
        div_start       = 1'b0;
        div_dividend    = {{(DIV_N_W-80){1'b0}}, fin_ticks_reg, 16'd0};
        div_divisor     = (cfg.core_clock_hz == 32'd0) ? 32'd1 : cfg.core_clock_hz;
        qc              = '0;

        // Accumulate the weighted product
        if (pa_valid_reg)
        begin
            sum_next = sum_reg + 64'($signed(pa_prod_reg));
        end

        case (state_reg)
            S_CLR:
            begin
                if (cnt_reg == CNT_W'(MAX_CHANNELS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ACC:
            begin
                if (q_pop && q_dout.last)
                begin
                    state_next = S_FIN0;
                end
            end
            S_FIN0:
            begin
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                neg_next = sum_reg[63];
                mag_next = sum_reg[63] ? 64'd0 - sum_reg : sum_reg;
                if (fin_verdict_reg != ST_OK)
                begin
                    stat_next  = fin_verdict_reg;
                    state_next = S_OUT;
                end
                else if (fin_live_reg <= cfg.min_delta)
                begin
                    stat_next  = ST_SHORT;
                    fp_next    = 1'b1;
                    state_next = S_OUT;
                end
                else if (fp_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_TDIV;
                end
                else if (d_s < -eps_s)
                begin
                    stat_next  = ST_BACK;
                    fp_next    = 1'b1;
                    state_next = S_OUT;
                end
                else if (d_s <= eps_s)
                begin
                    stat_next  = ST_NO_ADV;
                    state_next = S_OUT;
                end
                else if (d_s < min_s)
                begin
                    stat_next  = ST_SMALL;
                    state_next = S_OUT;
                end
                else
                begin
                    den_next   = d_s[31:0];
                    state_next = S_MUL0;
                end
            end
            S_TDIV:
            begin
                if (div_done)
                begin
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                if (div_ovf || (fin_live_reg <= div_quot) || sum_reg[63])
                begin
                    stat_next  = ST_BAD_INST;
                    state_next = S_OUT;
                end
                else
                begin
                    den_next   = fin_live_reg - div_quot;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                state_next = S_MADD;
            end
            S_MADD:
            begin
                div_start    = 1'b1;
                div_dividend = {n96, 6'd0};
                div_divisor  = den_reg;
                state_next   = S_RDIV;
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                // Sign and saturate the quotient
                if (neg_reg)
                begin
                    qc        = (q33 > 33'h0_8000_0000) ? 33'h0_8000_0000 : q33;
                    rate_next = 32'd0 - qc[31:0];
                end
                else
                begin
                    rate_next = (q33 > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q33[31:0];
                end
                stat_next  = ST_OK;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_rate_next   = (stat_reg == ST_OK) ? rate_reg : 32'd0;
                    if (stat_reg == ST_OK)
                    begin
                        prev_live_next = fin_live_reg;
                        fp_next        = 1'b0;
                        cnt_next       = '0;
                        state_next     = S_COPY;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_COPY:
            begin
                if (cp_more)
                begin
                    cp_wv_next = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else if (!cp_wv_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                sum_next   = '0;
                state_next = S_ACC;
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            sum_reg        <= '0;
            pa_valid_reg   <= 1'b0;
            fp_reg         <= 1'b1;
            prev_live_reg  <= '0;
            cnt_reg        <= '0;
            cp_wv_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sum_reg        <= sum_next;
            pa_valid_reg   <= pa_valid_next;
            fp_reg         <= fp_next;
            prev_live_reg  <= prev_live_next;
            cnt_reg        <= cnt_next;
            cp_wv_reg      <= cp_wv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pa_prod_reg <= PROD_W'($signed({1'b0, q_dout.x}) * $signed(q_dout.weight));
        end
        if (q_pop && q_dout.last)
        begin
            fin_live_reg    <= q_dout.live;
            fin_ticks_reg   <= q_dout.ticks;
            fin_total_reg   <= q_dout.total;
            fin_verdict_reg <= q_dout.verdict;
        end
        if (state_reg == S_MUL0)
        begin
            pp_lo_reg <= 64'(mag_reg[31:0]) * 64'(cfg.dz_scale);
        end
        if (state_reg == S_MUL1)
        begin
            pp_hi_reg <= 64'(mag_reg[63:32]) * 64'(cfg.dz_scale);
        end
        cp_wa_reg      <= cnt_reg[IDX_W-1:0];
        stat_reg       <= stat_next;
        den_reg        <= den_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        rate_reg       <= rate_next;
        out_rate_reg   <= out_rate_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign dose_rate = $signed(out_rate_reg);
    assign status    = out_status_reg;

`ifndef SYNTHESIS
    a_clr_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !ctl.ready && !q_pop)
        else $error("requests taken during memory clear");
    a_ok_has_zero_fp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) |-> !fp_reg)
        else $error("copy without a good result");
    a_rate_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_rate_reg == 32'd0))
        else $error("non-zero rate with an error status");
`endif

endmodule

@@ hw/rtl/spectrum_dose_rate_top.sv @@
// Top level of the spectrum dose-rate block: configuration, memories, front, queue, back.
//
//  channel  direction  handshake          payload
//  in       request    in_valid/in_stall  channel_count, channel_total, live_time,
//                                         record_ticks, last_channel
//  out      result     out_valid/out_stall dose_rate, status (one per spectrum)
//  cfg      write      cfg_we             cfg_index, cfg_data
//
// A channel request is taken every cycle while the queue has room and no spectrum is being
// finished; the multiply and accumulate run behind it at one channel per cycle.
// After the last channel the back part runs the serial divisions (one for the record time on
// a first measurement, one for the rate) and copies the spectrum after a good result; new
// requests wait for that.
// After reset the previous-spectrum memory is cleared before the first request is
// taken. Output stall holds the result and delays the next one.
module spectrum_dose_rate_top #(
    parameter int MAX_CHANNELS = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        channel_count,
    input  logic [15:0]        channel_total,
    input  logic [31:0]        live_time,
    input  logic [63:0]        record_ticks,
    input  logic               last_channel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] dose_rate,
    output logic [2:0]         status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import sdr_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHANNELS);

    cfg_t       cfg_reg, cfg_next;
    back_ctl_t  ctl;
    item_t      q_din, q_dout;
    logic       q_push, q_pop, q_full, q_empty;
    logic             prev_we, prev_re;
    logic [IDX_W-1:0] prev_waddr, prev_raddr;
    logic [31:0]      prev_wdata, prev_rdata;
    logic             stg_we, stg_re;
    logic [IDX_W-1:0] stg_waddr, stg_raddr;
    logic [31:0]      stg_wdata, stg_rdata;

    // Configuration register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DZ_SCALE:  cfg_next.dz_scale      = cfg_data;
                CFG_MIN_DELTA: cfg_next.min_delta     = cfg_data;
                CFG_TIME_EPS:  cfg_next.time_eps      = cfg_data;
                CFG_CLOCK_HZ:  cfg_next.core_clock_hz = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dz_scale      <= 32'd16777216;
            cfg_reg.min_delta     <= 32'd65536;
            cfg_reg.time_eps      <= 32'd66;
            cfg_reg.core_clock_hz <= 32'd50000000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdr_ram #(.W(32), .DEPTH(MAX_CHANNELS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (prev_re),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    sdr_ram #(.W(32), .DEPTH(MAX_CHANNELS)) u_stg_ram (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .re    (stg_re),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    sdr_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .channel_count (channel_count),
        .channel_total (channel_total),
        .live_time     (live_time),
        .record_ticks  (record_ticks),
        .last_channel  (last_channel),
        .ctl           (ctl),
        .prev_re       (prev_re),
        .prev_raddr    (prev_raddr),
        .prev_rdata    (prev_rdata),
        .stg_we        (stg_we),
        .stg_waddr     (stg_waddr),
        .stg_wdata     (stg_wdata),
        .q_push        (q_push),
        .q_din         (q_din),
        .q_full        (q_full)
    );

    sdr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    sdr_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_dout     (q_dout),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .ctl        (ctl),
        .prev_we    (prev_we),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .stg_re     (stg_re),
        .stg_raddr  (stg_raddr),
        .stg_rdata  (stg_rdata),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dose_rate  (dose_rate),
        .status     (status)
    );

endmodule

@@ tb/tb_spectrum_dose_rate_top.sv @@
// Self-checking testbench of the spectrum dose-rate block with its own rate predictor.
`timescale 1ns / 1ps

module tb_spectrum_dose_rate_top;
    import sdr_pkg::*;

    localparam int MAX_CH   = 4096;
    // copy pass plus two serial divisions, with margin
    localparam int SETTLE   = MAX_CH + 600;

    typedef struct {
        logic [31:0] count;
        logic [15:0] total;
        logic [31:0] live;
        logic [63:0] ticks;
        logic        last;
    } chan_req_t;

    typedef struct {
        logic [31:0] rate;
        logic [2:0]  st;
    } dose_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [31:0]        channel_count = '0;
    logic [15:0]        channel_total = '0;
    logic [31:0]        live_time = '0;
    logic [63:0]        record_ticks = '0;
    logic               last_channel = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] dose_rate;
    logic [2:0]         status;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    chan_req_t   pending_reqs[$];
    dose_res_t   expected_doses[$];
    logic        calm = 1'b0;
    int          fail_count = 0;
    int          doses_seen = 0;

    // predictor state
    cfg_t        cfg_copy;
    logic [31:0] prev_counts [MAX_CH];
    logic [31:0] staged_counts [MAX_CH];
    logic [31:0] prev_live;
    logic        first_meas;
    int          chan_idx;
    logic [63:0] wsum;
    logic [2:0]  verdict;

    // stimulus generator state
    logic [31:0] gen_live;

    spectrum_dose_rate_top #(.MAX_CHANNELS(MAX_CH)) u_dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Scale |sum| by dz * 64 / den, cap, and apply the sign of the sum
    function automatic logic [31:0] scaled_rate(input logic [63:0] s4, input logic [63:0] den);
        logic          neg;
        logic [63:0]   mag;
        logic [127:0]  q;
        neg = s4[63];
        mag = neg ? (~s4) + 64'd1 : s4;
        q = (({64'd0, mag} * {96'd0, cfg_copy.dz_scale}) << 6) / {64'd0, den};
        if (neg)
        begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return 32'd0 - q[31:0];
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return q[31:0];
    endfunction

    // Advance the predictor by one accepted channel request
    task automatic dose_model_step(input chan_req_t r);
        int          k;
        logic [31:0] x;
        longint      w;
        logic [63:0] clk_hz, q, rem, t;
        longint      d;
        dose_res_t   res;
        k = -1;
        for (int j = 0; j < 6; j++)
        begin
            if (r.total == (16'd128 << j)) k = j;
        end
        if (k < 0)
        begin
            if (verdict == ST_OK) verdict = ST_BAD_TOTAL;
        end
        else if (chan_idx >= r.total || chan_idx >= MAX_CH)
        begin
            if (verdict == ST_OK) verdict = ST_LEN;
        end
        else
        begin
            x = r.count;
            if (!first_meas)
                x = (r.count > prev_counts[chan_idx]) ? r.count - prev_counts[chan_idx] : 32'd0;
            w = (longint'(chan_idx) - 10) * longint'(96 >> k);
            wsum += 64'(longint'({32'd0, x}) * w);
            staged_counts[chan_idx] = r.count;
        end
        if (chan_idx < MAX_CH) chan_idx++;
        if (!r.last) return;

        if (verdict == ST_OK && (k < 0 || chan_idx != r.total))
            verdict = (k < 0) ? ST_BAD_TOTAL : ST_LEN;
        res.rate = '0;
        res.st = ST_OK;
        if (verdict != ST_OK)
            res.st = verdict;
        else if (r.live <= cfg_copy.min_delta)
        begin
            res.st = ST_SHORT;
            first_meas = 1'b1;
        end
        else if (first_meas)
        begin
            clk_hz = (cfg_copy.core_clock_hz == 0) ? 64'd1 : {32'd0, cfg_copy.core_clock_hz};
            q = r.ticks / clk_hz;
            rem = r.ticks % clk_hz;
            if (q >= 64'd65536)
                res.st = ST_BAD_INST;
            else
            begin
                t = (q << 16) + ((rem << 16) / clk_hz);
                if ({32'd0, r.live} <= t || wsum[63])
                    res.st = ST_BAD_INST;
                else
                    res.rate = scaled_rate(wsum, {32'd0, r.live} - t);
            end
        end
        else
        begin
            d = longint'({32'd0, r.live}) - longint'({32'd0, prev_live});
            if (d < -longint'({32'd0, cfg_copy.time_eps}))
            begin
                res.st = ST_BACK;
                first_meas = 1'b1;
            end
            else if (d <= longint'({32'd0, cfg_copy.time_eps}))
                res.st = ST_NO_ADV;
            else if (d < longint'({32'd0, cfg_copy.min_delta}))
                res.st = ST_SMALL;
            else
                res.rate = scaled_rate(wsum, 64'(d));
        end
        if (res.st == ST_OK)
        begin
            for (int i = 0; i < r.total; i++) prev_counts[i] = staged_counts[i];
            prev_live = r.live;
            first_meas = 1'b0;
        end
        else
            res.rate = '0;
        chan_idx = 0;
        wsum = '0;
        verdict = ST_OK;
        expected_doses.push_back(res);
    endtask

    // Driver: offer queued requests, with random gaps
    int gap_left = 0;
    always @(posedge clk)
    begin
        chan_req_t r;
        if (in_valid && !in_stall)
        begin
            r.count = channel_count;
            r.total = channel_total;
            r.live = live_time;
            r.ticks = record_ticks;
            r.last = last_channel;
            dose_model_step(r);
        end
        if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 19) == 0)
            begin
                gap_left <= $urandom_range(0, 12);
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                channel_count <= r.count;
                channel_total <= r.total;
                live_time <= r.live;
                record_ticks <= r.ticks;
                last_channel <= r.last;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check results and drive output stall, with one long hold-off
    int stall_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    always @(posedge clk)
    begin
        dose_res_t e;
        if (out_valid && !out_stall)
        begin
            doses_seen <= doses_seen + 1;
            if (expected_doses.size() == 0)
            begin
                $display("%0t: unexpected result rate=%h status=%0d", $time, dose_rate, status);
                fail_count++;
            end
            else
            begin
                e = expected_doses.pop_front();
                if (e.rate !== dose_rate)
                begin
                    $display("%0t: dose_rate expected %h actual %h", $time, e.rate, dose_rate);
                    fail_count++;
                end
                if (e.st !== status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    fail_count++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && doses_seen == 8)
        begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 15) == 0)
        begin
            stall_left <= $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Queue one spectrum; bad_at >= 0 corrupts that item's length field
    task automatic push_spectrum(input int total, input int n_items, input logic [31:0] live,
                                 input logic [63:0] ticks, input int cmax,
                                 input logic low_only, input int bad_at);
        chan_req_t r;
        for (int i = 0; i < n_items; i++)
        begin
            r.count = (cmax == 0) ? $urandom : $urandom_range(0, cmax);
            if (low_only && i >= 10) r.count = '0;
            r.total = 16'(total);
            if (i == bad_at) r.total = 16'($urandom_range(0, 127)) | 16'h8000;
            r.last = (i == n_items - 1);
            r.live = r.last ? live : $urandom;
            r.ticks = r.last ? ticks : rand64();
            pending_reqs.push_back(r);
        end
    endtask

    // Record ticks that mostly keep the record time below the live time
    function automatic logic [63:0] pick_ticks(input logic [31:0] live);
        logic [63:0] clk_hz, bound;
        clk_hz = (cfg_copy.core_clock_hz == 0) ? 64'd1 : {32'd0, cfg_copy.core_clock_hz};
        bound = ({48'd0, live[31:16]} * clk_hz) >> 1;
        if ($urandom_range(0, 7) == 0) return rand64();
        return rand64() % (bound + 64'd1);
    endfunction

    // Next live time: mostly a healthy step, sometimes each kind of bad step
    function automatic logic [31:0] pick_live();
        case ($urandom_range(0, 11))
            0: return gen_live - $urandom_range(100, 1 << 20);
            1: return gen_live + $urandom_range(0, cfg_copy.time_eps > 100 ? 100 : 0);
            2: return gen_live + cfg_copy.time_eps + 1;
            3: return $urandom_range(0, cfg_copy.min_delta > 65535 ? 65535 : 0);
            4: return $urandom;
            default: return gen_live + cfg_copy.min_delta + $urandom_range(1, 1 << 22);
        endcase
    endfunction

    task automatic random_spectra(input int n);
        int total, n_items, bad_at, cmax;
        logic [31:0] live;
        for (int s = 0; s < n; s++)
        begin
            total = ($urandom_range(0, 7) == 0) ? (128 << $urandom_range(1, 2)) : 128;
            n_items = total;
            bad_at = -1;
            case ($urandom_range(0, 19))
                0: n_items = $urandom_range(1, total - 1);
                1: n_items = total + $urandom_range(1, 5);
                2: bad_at = $urandom_range(0, total - 1);
                default: ;
            endcase
            cmax = ($urandom_range(0, 9) == 0) ? 0 : (1 << $urandom_range(0, 12));
            live = pick_live();
            gen_live = live;
            push_spectrum(total, n_items, live, pick_ticks(live), cmax, 1'b0, bad_at);
        end
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_doses.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DZ_SCALE:  cfg_copy.dz_scale = val;
            CFG_MIN_DELTA: cfg_copy.min_delta = val;
            CFG_TIME_EPS:  cfg_copy.time_eps = val;
            default:       cfg_copy.core_clock_hz = val;
        endcase
    endtask

    task automatic write_all(input logic [31:0] dz, input logic [31:0] md,
                             input logic [31:0] eps, input logic [31:0] hz);
        wait_idle();
        write_cfg(CFG_DZ_SCALE, dz);
        write_cfg(CFG_MIN_DELTA, md);
        write_cfg(CFG_TIME_EPS, eps);
        write_cfg(CFG_CLOCK_HZ, hz);
    endtask

    initial
    begin
        cfg_copy = '{dz_scale: 32'd16777216, min_delta: 32'd65536, time_eps: 32'd66,
                     core_clock_hz: 32'd50000000};
        for (int i = 0; i < MAX_CH; i++)
        begin
            prev_counts[i] = '0;
            staged_counts[i] = '0;
        end
        prev_live = '0;
        first_meas = 1'b1;
        chan_idx = 0;
        wsum = '0;
        verdict = ST_OK;
        gen_live = 32'h0010_0000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // defaults, and a small clock so record times are easy to place
        write_all(32'd16777216, 32'd65536, 32'd66, 32'd1000);
        // directed: bad totals, a length mismatch, an overrun, a negative instant sum
        push_spectrum(16'hFFFF, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0, -1);
        push_spectrum(8192, 1, 32'd0, 64'd0, 0, 1'b0, -1);
        push_spectrum(0, 2, 32'd0, 64'd0, 0, 1'b0, -1);
        push_spectrum(128, 3, 32'h0020_0000, 64'd0, 0, 1'b0, -1);
        push_spectrum(128, 130, 32'h0020_0000, 64'd0, 0, 1'b0, -1);
        push_spectrum(128, 128, 32'h0020_0000, 64'd10, 100, 1'b1, -1);
        push_spectrum(128, 128, 32'h0020_0000, 64'd200, 0, 1'b0, -1);
        push_spectrum(128, 128, 32'h0010_0000, 64'd0, 50, 1'b0, -1);
        gen_live = 32'h0010_0000;
        random_spectra(14);
        push_spectrum(4096, 4096, gen_live + 32'h0004_0000, 64'd5, 0, 1'b0, -1);
        gen_live = gen_live + 32'h0004_0000;
        push_spectrum(4096, 4096, gen_live + 32'h0100_0000, 64'd5, 3, 1'b0, -1);
        gen_live = gen_live + 32'h0100_0000;

        // zero extremes: clock of zero counts as one
        write_all(32'd0, 32'd0, 32'd0, 32'd0);
        random_spectra(8);

        // full-scale extremes
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_spectra(4);

        // random mid-range settings
        write_all($urandom_range(1, 1 << 20), $urandom_range(1, 1 << 18),
                  $urandom_range(0, 1 << 10), $urandom_range(1, 1 << 24));
        random_spectra(12);

        // last part runs without idling
        write_all($urandom, $urandom_range(0, 1 << 17), $urandom_range(0, 4096),
                  $urandom_range(1, 100000));
        calm <= 1'b1;
        random_spectra(10);

        wait_idle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
